// ===== sv/isotp_rr_pkg.sv =====
// Shared types, constants and helpers of the ISO-TP request receiver.
package isotp_rr_pkg;

  typedef enum logic [1:0] {
    KIND_TX  = 2'd0,
    KIND_PAY = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  localparam logic       OP_START     = 1'b0;
  localparam logic [7:0] PCI_SF_REQ   = 8'h02;
  localparam logic [7:0] PCI_FC       = 8'h30;
  localparam logic [3:0] FT_SINGLE    = 4'h0;
  localparam logic [3:0] FT_FIRST     = 4'h1;
  localparam logic [3:0] SF_MAX_LEN   = 4'd7;
  localparam logic [3:0] FF_DATA_LEN  = 4'd6;
  localparam logic [3:0] FRAME_BYTES  = 4'd8;

  localparam logic [1:0] REG_REQUEST_ID = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0] REG_SEP_TIME   = 2'd2;
  localparam logic [1:0] REG_PAD_BYTE   = 2'd3;

  localparam logic [10:0] RST_REQUEST_ID = 11'h7DF;
  localparam logic [7:0]  RST_BLOCK_SIZE = 8'h00;
  localparam logic [7:0]  RST_SEP_TIME   = 8'h0A;
  localparam logic [7:0]  RST_PAD_BYTE   = 8'hAA;

  typedef struct packed {
    logic        operation;
    logic [7:0]  service;
    logic [7:0]  pid;
    logic [63:0] rx_frame;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] tx_id;
    logic [63:0] frame_bytes;
    logic [3:0]  byte_count;
    logic [11:0] total_length;
    logic        done_res;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [10:0] request_id;
    logic [7:0]  block_size;
    logic [7:0]  separation_time;
    logic [7:0]  pad_byte;
  } cfg_t;

  // classified work handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [63:0] bytes;
    logic [3:0]  count;
    logic [11:0] total;
    logic        done;
    logic        flow;
  } cmd_t;

  function automatic logic [63:0] padded(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] pad);
    return {b0, b1, b2, pad, pad, pad, pad, pad};
  endfunction

  // keep the first n bytes of an already aligned word
  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [3:0] n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        r[63-8*i -: 8] = w[63-8*i -: 8];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/isotp_rr_front.sv =====
// Front end: accepts words, tracks the transaction and classifies each word.
module isotp_rr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  isotp_rr_pkg::in_t   in_data,
  input  isotp_rr_pkg::cfg_t  cfg,
  output logic                cmd_valid,
  output isotp_rr_pkg::cmd_t  cmd
);
  import isotp_rr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_FIRST = 2'd1,
    PH_WAIT_CONS  = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [11:0] deliv_r, deliv_nxt;
  logic [7:0]  fuf_r, fuf_nxt;
  logic        produce;

  logic [7:0]  b0;
  logic [3:0]  ftype;
  logic [11:0] ff_len;
  logic [3:0]  sf_n;
  logic [3:0]  cf_n;
  logic [11:0] cf_left;

  always_comb begin
    b0      = in_data.rx_frame[63:56];
    ftype   = b0[7:4];
    ff_len  = {b0[3:0], in_data.rx_frame[55:48]};
    sf_n    = (b0[3:0] > SF_MAX_LEN) ? SF_MAX_LEN : b0[3:0];
    cf_n    = (rem_r < 12'(SF_MAX_LEN)) ? rem_r[3:0] : SF_MAX_LEN;
    cf_left = rem_r - 12'(cf_n);

    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    deliv_nxt = deliv_r;
    fuf_nxt   = fuf_r;
    produce   = 1'b0;
    cmd       = '0;

    if (in_data.operation == OP_START) begin
      produce   = 1'b1;
      deliv_nxt = '0;
      rem_nxt   = '0;
      fuf_nxt   = '0;
      phase_nxt = PH_WAIT_FIRST;
      cmd.kind  = KIND_TX;
      cmd.bytes = padded(PCI_SF_REQ, in_data.service, in_data.pid, cfg.pad_byte);
      cmd.count = FRAME_BYTES;
    end else begin
      unique case (phase_r)
        PH_WAIT_FIRST: begin
          produce   = 1'b1;
          phase_nxt = PH_IDLE;
          cmd.done  = 1'b1;
          if (ftype == FT_SINGLE) begin
            deliv_nxt = deliv_r + 12'(sf_n);
            cmd.kind  = KIND_PAY;
            cmd.bytes = keep_bytes({in_data.rx_frame[55:0], 8'h00}, sf_n);
            cmd.count = sf_n;
          end else if (ftype == FT_FIRST) begin
            cmd.kind = KIND_PAY;
            if (ff_len <= 12'(FF_DATA_LEN)) begin
              deliv_nxt = deliv_r + ff_len;
              rem_nxt   = '0;
              cmd.bytes = keep_bytes({in_data.rx_frame[47:0], 16'h0000}, ff_len[3:0]);
              cmd.count = ff_len[3:0];
            end else begin
              deliv_nxt = deliv_r + 12'(FF_DATA_LEN);
              rem_nxt   = ff_len - 12'(FF_DATA_LEN);
              phase_nxt = PH_WAIT_CONS;
              fuf_nxt   = cfg.block_size;
              cmd.bytes = {in_data.rx_frame[47:0], 16'h0000};
              cmd.count = FF_DATA_LEN;
              cmd.done  = 1'b0;
              cmd.flow  = 1'b1;
            end
          end else begin
            rem_nxt  = '0;
            cmd.kind = KIND_ERR;
          end
          cmd.total = deliv_nxt;
        end
        PH_WAIT_CONS: begin
          produce   = 1'b1;
          deliv_nxt = deliv_r + 12'(cf_n);
          rem_nxt   = cf_left;
          cmd.kind  = KIND_PAY;
          cmd.bytes = keep_bytes({in_data.rx_frame[55:0], 8'h00}, cf_n);
          cmd.count = cf_n;
          cmd.total = deliv_nxt;
          if (cf_left == '0) begin
            phase_nxt = PH_IDLE;
            cmd.done  = 1'b1;
          end else if (fuf_r == 8'd1) begin
            fuf_nxt  = cfg.block_size;
            cmd.flow = 1'b1;
          end else if (fuf_r != '0) begin
            fuf_nxt = fuf_r - 8'd1;
          end
        end
        default: ;
      endcase
    end
    cmd_valid = accept && produce;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rem_r   <= '0;
      deliv_r <= '0;
      fuf_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      deliv_r <= deliv_nxt;
      fuf_r   <= fuf_nxt;
    end
  end

endmodule

// ===== sv/isotp_rr_queue.sv =====
// Two-entry queue of classified work between front and back.
module isotp_rr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  isotp_rr_pkg::cmd_t  wr_cmd,
  input  logic                rd_en,
  output logic                rd_valid,
  output isotp_rr_pkg::cmd_t  rd_cmd,
  output logic                full
);
  import isotp_rr_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign rd_valid = count_r != 2'd0;
  assign full     = count_r == 2'd2;
  assign rd_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/isotp_rr_back.sv =====
// Back end: expands classified work into result words in the output register.
module isotp_rr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  isotp_rr_pkg::cmd_t  q_cmd,
  input  isotp_rr_pkg::cfg_t  cfg,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output isotp_rr_pkg::out_t  out_data
);
  import isotp_rr_pkg::*;

  logic out_valid_r;
  out_t out_r, out_nxt;
  logic step_r;
  logic load;

  assign load     = q_valid && (!out_valid_r || pop);
  assign q_pop    = load && (step_r || !q_cmd.flow);
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    out_nxt = '0;
    if (step_r) begin
      // flow control after first or block-ending consecutive frame
      out_nxt.kind         = KIND_TX;
      out_nxt.tx_id        = cfg.request_id;
      out_nxt.frame_bytes  = padded(PCI_FC, cfg.block_size, cfg.separation_time,
                                    cfg.pad_byte);
      out_nxt.byte_count   = FRAME_BYTES;
      out_nxt.total_length = q_cmd.total;
      out_nxt.last         = 1'b1;
    end else begin
      out_nxt.kind         = q_cmd.kind;
      out_nxt.tx_id        = (q_cmd.kind == KIND_TX) ? cfg.request_id : '0;
      out_nxt.frame_bytes  = q_cmd.bytes;
      out_nxt.byte_count   = q_cmd.count;
      out_nxt.total_length = q_cmd.total;
      out_nxt.done_res     = q_cmd.done;
      out_nxt.last         = !q_cmd.flow;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= !step_r && q_cmd.flow;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== sv/isotp_request_receive_fsm.sv =====
// Top level of the ISO-TP request receiver: config registers, front, queue, back.
// A start word sends a padded single-frame request; received frames then yield payload
// words, flow-control frames and errors. The front takes one word per cycle while the
// two-entry work queue has room; the back writes one result word per cycle into the
// output register while it is empty or popped, so a word that gives one result
// sustains one word per cycle, and a first frame or block-ending consecutive frame
// also gives a flow-control frame and holds the back until both are written. The user
// must write registers over APB only while the block is idle; the block does not enforce this.
module isotp_request_receive_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  isotp_rr_pkg::in_t   in_data,
  output logic                empty,
  input  logic                pop,
  output isotp_rr_pkg::out_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import isotp_rr_pkg::*;

  cfg_t cfg_r;
  logic cfg_wr;
  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.request_id      <= RST_REQUEST_ID;
      cfg_r.block_size      <= RST_BLOCK_SIZE;
      cfg_r.separation_time <= RST_SEP_TIME;
      cfg_r.pad_byte        <= RST_PAD_BYTE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_REQUEST_ID: cfg_r.request_id      <= pwdata[10:0];
        REG_BLOCK_SIZE: cfg_r.block_size      <= pwdata[7:0];
        REG_SEP_TIME:   cfg_r.separation_time <= pwdata[7:0];
        REG_PAD_BYTE:   cfg_r.pad_byte        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_REQUEST_ID: prdata = 32'(cfg_r.request_id);
      REG_BLOCK_SIZE: prdata = 32'(cfg_r.block_size);
      REG_SEP_TIME:   prdata = 32'(cfg_r.separation_time);
      REG_PAD_BYTE:   prdata = 32'(cfg_r.pad_byte);
      default: ;
    endcase
  end

  isotp_rr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  isotp_rr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_valid),
    .wr_cmd   (cmd),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .full     (full)
  );

  isotp_rr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .cfg      (cfg_r),
    .pop      (pop),
    .q_pop    (q_pop),
    .empty    (empty),
    .out_data (out_data)
  );

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.kind == KIND_ERR) |-> (out_data.done_res && out_data.last))
    else $error("error word does not end the transaction");

  a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.last) |-> (out_data.kind == KIND_PAY && !out_data.done_res))
    else $error("non-final word is not a payload word");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.last && pop) |=>
      (!empty && out_data.kind == KIND_TX && out_data.last))
    else $error("flow-control frame does not follow its payload word");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule
